// ===== sv/rgbc_pkg.sv =====
// Shared types, constants and helper functions of the RGB 3x3 convolution core.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rgbc_pkg;

    // Frame geometry and coefficient format.
    localparam int MaxWidth      = 2048;
    localparam int MaxHeight     = 4096;
    localparam int CoefFracBits  = 8;
    localparam int CoefBits      = CoefFracBits + 4;
    localparam int CoefRowBits   = 3 * CoefBits;
    localparam int KSize         = 3;
    localparam int ColBits       = $clog2(MaxWidth);
    localparam int WEffBits      = ColBits + 1;
    localparam int WidthRegBits  = 12;
    localparam int HeightRegBits = 13;
    // Rows run up to two past the frame height before the frame closes.
    localparam int RowBits       = $clog2(MaxHeight + 3);
    localparam int ChanBits      = 8;
    localparam int NumChan       = 3;
    localparam int ProdBits      = ChanBits + 1 + CoefBits;
    localparam int RowSumBits    = ProdBits + 2;
    localparam int SumBits       = ProdBits + 4;

    // Register port geometry: registers are 64 bits wide, one every 8 bytes.
    localparam int ApbDataBits   = 64;
    localparam int RegIdxBits    = 3;
    localparam int PaddrBits     = RegIdxBits + 3;

    typedef logic [RegIdxBits-1:0] t_reg_idx;
    localparam t_reg_idx RegCoefTop     = 3'd0;
    localparam t_reg_idx RegCoefMiddle  = 3'd1;
    localparam t_reg_idx RegCoefBottom  = 3'd2;
    localparam t_reg_idx RegImageWidth  = 3'd3;
    localparam t_reg_idx RegImageHeight = 3'd4;

    // One RGB pixel, red in the low byte.
    typedef struct packed {
        logic [ChanBits-1:0] blue;
        logic [ChanBits-1:0] green;
        logic [ChanBits-1:0] red;
    } t_pix;

    // One line buffer entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_line_entry;

    // Per-item control that follows the pixel down the pipeline.
    typedef struct packed {
        logic emit;
        logic last;
        logic row_top_ok;
        logic row_bot_ok;
        logic col_left_ok;
        logic col_right_ok;
    } t_tap_ctl;

    // 3x3 neighborhood, indexed [row][column], column 0 on the left.
    typedef t_pix [KSize-1:0][KSize-1:0] t_window;

    // Signed coefficient k of a kernel row register.
    function automatic logic signed [CoefBits-1:0] coef_at(
        input logic [CoefRowBits-1:0] row,
        input int                     k
    );
        return $signed(row[k*CoefBits +: CoefBits]);
    endfunction

    // Truncate toward zero and saturate to one channel.
    function automatic logic [ChanBits-1:0] clamp_sum(input logic signed [SumBits-1:0] s);
        logic [SumBits-CoefFracBits-1:0] v;
        v = s[SumBits-1:CoefFracBits];
        if (s[SumBits-1] || s == '0) begin
            return '0;
        end
        if (v > (SumBits-CoefFracBits)'(2**ChanBits - 1)) begin
            return '1;
        end
        return v[ChanBits-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/rgbc_line_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on rgbc_pkg only for its default sizes.
`default_nettype none

module rgbc_line_ram import rgbc_pkg::*; #(
    parameter int Depth = MaxWidth,
    parameter int Width = $bits(t_line_entry)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic      [Width-1:0]         o_rd_data,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_wr_addr,
    input  wire logic [Width-1:0]         i_wr_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/rgbc_window.sv =====
// Line buffer read-modify-write stage and the 3x3 window registers.
// Depends on rgbc_pkg; drives the write port of rgbc_line_ram.
`default_nettype none

module rgbc_window import rgbc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic [ColBits-1:0] i_rd_addr,
    input  wire logic               i_b_valid,
    input  wire logic [ColBits-1:0] i_b_addr,
    input  wire t_pix               i_b_cur,
    input  wire t_tap_ctl           i_b_ctl,
    input  wire t_line_entry        i_rd_data,
    output logic                    o_we,
    output logic [ColBits-1:0]      o_wr_addr,
    output t_line_entry             o_wr_data,
    output t_window                 o_win,
    output logic                    o_c_valid,
    output t_tap_ctl                o_c_ctl
);

    logic        r_hit;
    t_line_entry r_byp;
    t_line_entry col_data;
    t_window     r_win;
    logic        r_c_valid;
    t_tap_ctl    r_c_ctl;

    // A read issued at the same edge as a write to that column sees stale data,
    // so the written entry is kept and used instead.
    assign col_data  = r_hit ? r_byp : i_rd_data;

    // Shift the column down: the newer row becomes the older one.
    assign o_we      = i_adv && i_b_valid;
    assign o_wr_addr = i_b_addr;
    assign o_wr_data = t_line_entry'({col_data.newer, i_b_cur});

    // Forwarding flag and data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_adv) begin
            r_hit <= i_b_valid && (i_rd_addr == i_b_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_byp <= o_wr_data;
        end
    end

    // Window shifts left by one column for every pixel slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (o_we) begin
            for (int r = 0; r < KSize; r++) begin
                for (int k = 0; k < KSize - 1; k++) begin
                    r_win[r][k] <= r_win[r][k+1];
                end
            end
            r_win[0][KSize-1] <= col_data.older;
            r_win[1][KSize-1] <= col_data.newer;
            r_win[2][KSize-1] <= i_b_cur;
        end
    end

    // Control of the next stage; only slots that give an output go on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_c_valid <= i_b_valid && i_b_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_ctl <= i_b_ctl;
        end
    end

    assign o_win     = r_win;
    assign o_c_valid = r_c_valid;
    assign o_c_ctl   = r_c_ctl;

endmodule

`default_nettype wire

// ===== sv/rgbc_mac.sv =====
// Multiply, row-sum and clamp pipeline with the output register.
// Depends on rgbc_pkg; fed by the window of rgbc_window.
`default_nettype none

module rgbc_mac import rgbc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_adv,
    input  wire logic                   i_valid,
    input  wire t_tap_ctl               i_ctl,
    input  wire t_window                i_win,
    input  wire logic [CoefRowBits-1:0] i_coef_top,
    input  wire logic [CoefRowBits-1:0] i_coef_mid,
    input  wire logic [CoefRowBits-1:0] i_coef_bot,
    output logic                        o_valid,
    output t_pix                        o_pix,
    output logic                        o_last
);

    function automatic logic [ChanBits-1:0] chan_of(input t_pix p, input int ch);
        case (ch)
            0:       return p.red;
            1:       return p.green;
            default: return p.blue;
        endcase
    endfunction

    logic [CoefRowBits-1:0]       coef_rows [KSize];
    logic [KSize-1:0]             row_ok;
    logic [KSize-1:0]             col_ok;
    logic signed [ProdBits-1:0]   n_prod    [NumChan][KSize][KSize];
    logic signed [ProdBits-1:0]   r_prod    [NumChan][KSize][KSize];
    logic signed [RowSumBits-1:0] n_row_sum [NumChan][KSize];
    logic signed [RowSumBits-1:0] r_row_sum [NumChan][KSize];
    logic signed [SumBits-1:0]    total     [NumChan];
    logic                         r_d_valid;
    logic                         r_d_last;
    logic                         r_e_valid;
    logic                         r_e_last;
    logic                         r_out_valid;
    logic                         r_out_last;
    t_pix                         r_out_pix;
    t_pix                         n_out_pix;

    // Products; taps that fall outside the frame contribute zero.
    always_comb begin
        coef_rows[0] = i_coef_top;
        coef_rows[1] = i_coef_mid;
        coef_rows[2] = i_coef_bot;
        row_ok = '1;
        col_ok = '1;
        row_ok[0]       = i_ctl.row_top_ok;
        row_ok[KSize-1] = i_ctl.row_bot_ok;
        col_ok[0]       = i_ctl.col_left_ok;
        col_ok[KSize-1] = i_ctl.col_right_ok;
        for (int ch = 0; ch < NumChan; ch++) begin
            for (int r = 0; r < KSize; r++) begin
                for (int k = 0; k < KSize; k++) begin
                    if (row_ok[r] && col_ok[k]) begin
                        n_prod[ch][r][k] = $signed({1'b0, chan_of(i_win[r][k], ch)})
                                           * coef_at(coef_rows[r], k);
                    end else begin
                        n_prod[ch][r][k] = '0;
                    end
                end
            end
        end
    end

    // Sum of each kernel row.
    always_comb begin
        for (int ch = 0; ch < NumChan; ch++) begin
            for (int r = 0; r < KSize; r++) begin
                n_row_sum[ch][r] = '0;
                for (int k = 0; k < KSize; k++) begin
                    n_row_sum[ch][r] = n_row_sum[ch][r] + RowSumBits'(r_prod[ch][r][k]);
                end
            end
        end
    end

    // Full sum, then truncation and saturation.
    always_comb begin
        for (int ch = 0; ch < NumChan; ch++) begin
            total[ch] = '0;
            for (int r = 0; r < KSize; r++) begin
                total[ch] = total[ch] + SumBits'(r_row_sum[ch][r]);
            end
        end
        n_out_pix.red   = clamp_sum(total[0]);
        n_out_pix.green = clamp_sum(total[1]);
        n_out_pix.blue  = clamp_sum(total[2]);
    end

    // Stage valid bits; the whole chain moves together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_d_valid   <= i_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod     <= n_prod;
            r_d_last   <= i_ctl.last;
            r_row_sum  <= n_row_sum;
            r_e_last   <= r_d_last;
            r_out_pix  <= n_out_pix;
            r_out_last <= r_e_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out_pix;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

// ===== sv/rgbc_core_top.sv =====
// Top level of the RGB 3x3 convolution core: registers, raster counters, stage B.
// Depends on rgbc_pkg, rgbc_line_ram, rgbc_window and rgbc_mac.
//
//  Channel   | Port group     | Beat contents
//  ----------+----------------+-----------------------------------------------
//  pixel in  | s_axis_*       | tdata: red, green, blue; tuser: drain tick
//  pixel out | m_axis_*       | tdata: red, green, blue; tlast: last of frame
//  registers | psel/penable.. | 64-bit registers at byte address 8*index
//
// One beat is taken per clock while the output side does not stall; the RAM
// read-modify-write with a one-entry forward sets this pace. A beat is accepted in
// the cycle it reads the line buffer RAM, writes the column back from stage B, and
// its output then passes the window, product, row-sum and output registers. A stall
// on the output side holds the whole pipeline and drops s_axis_tready in the same
// cycle. Reset clears the counters, the window and the registers; the line buffer RAM is not cleared.
`default_nettype none

module rgb_convolution_3x3_core import rgbc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Pixel input.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [23:0]            s_axis_tdata,  // in_red, in_green, in_blue
    input  wire logic                   s_axis_tuser,  // operation
    // Pixel output.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [23:0]                 m_axis_tdata,  // out_red, out_green, out_blue
    output logic                        m_axis_tlast,  // last_of_frame
    // Register port.
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PaddrBits-1:0]   paddr,
    input  wire logic [ApbDataBits-1:0] pwdata,
    output logic [ApbDataBits-1:0]      prdata,
    output logic                        pready
);

    logic [CoefRowBits-1:0]   r_coef_top;
    logic [CoefRowBits-1:0]   r_coef_mid;
    logic [CoefRowBits-1:0]   r_coef_bot;
    logic [WidthRegBits-1:0]  r_image_width;
    logic [HeightRegBits-1:0] r_image_height;
    t_reg_idx                 reg_idx;
    logic                     reg_wr;

    logic [ColBits-1:0]       r_col;
    logic [RowBits-1:0]       r_row;
    logic [ColBits-1:0]       n_col;
    logic [RowBits-1:0]       n_row;
    logic [WEffBits-1:0]      w_eff;
    logic [WEffBits-1:0]      w_m1;
    logic [RowBits-1:0]       h_eff;
    logic [ColBits-1:0]       col_pre;
    logic [RowBits-1:0]       row_pre;
    logic [WEffBits-1:0]      col_inc;
    logic [RowBits-1:0]       orow;
    logic [ColBits-1:0]       ocol;
    logic                     in_frame;
    logic                     ignore_beat;
    t_pix                     cur;
    t_tap_ctl                 ctl;

    logic                     adv;
    logic                     s_fire;
    logic                     take;
    logic                     r_b_valid;
    logic [ColBits-1:0]       r_b_addr;
    t_pix                     r_b_cur;
    t_tap_ctl                 r_b_ctl;

    logic [$bits(t_line_entry)-1:0] ram_rd_data;
    logic                           ram_we;
    logic [ColBits-1:0]             ram_wr_addr;
    t_line_entry                    ram_wr_data;
    t_window                        win;
    logic                           c_valid;
    t_tap_ctl                       c_ctl;
    logic                           out_valid;
    t_pix                           out_pix;
    logic                           out_last;

    // Register writes.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PaddrBits-1:3]);
    assign reg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top     <= '0;
            r_coef_mid     <= CoefRowBits'(1 << (CoefFracBits + CoefBits));
            r_coef_bot     <= '0;
            r_image_width  <= WidthRegBits'(2048);
            r_image_height <= HeightRegBits'(1);
        end else if (reg_wr) begin
            case (reg_idx)
                RegCoefTop:     r_coef_top     <= pwdata[CoefRowBits-1:0];
                RegCoefMiddle:  r_coef_mid     <= pwdata[CoefRowBits-1:0];
                RegCoefBottom:  r_coef_bot     <= pwdata[CoefRowBits-1:0];
                RegImageWidth:  r_image_width  <= pwdata[WidthRegBits-1:0];
                RegImageHeight: r_image_height <= pwdata[HeightRegBits-1:0];
                default:        ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_idx)
            RegCoefTop:     prdata = ApbDataBits'(r_coef_top);
            RegCoefMiddle:  prdata = ApbDataBits'(r_coef_mid);
            RegCoefBottom:  prdata = ApbDataBits'(r_coef_bot);
            RegImageWidth:  prdata = ApbDataBits'(r_image_width);
            RegImageHeight: prdata = ApbDataBits'(r_image_height);
            default:        prdata = '0;
        endcase
    end

    // Effective frame size: zero acts as one, oversize saturates.
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WEffBits'(1);
        end else if (32'(r_image_width) > MaxWidth) begin
            w_eff = WEffBits'(MaxWidth);
        end else begin
            w_eff = WEffBits'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = RowBits'(1);
        end else if (32'(r_image_height) > MaxHeight) begin
            h_eff = RowBits'(MaxHeight);
        end else begin
            h_eff = RowBits'(r_image_height);
        end
        w_m1 = w_eff - 1'b1;
    end

    // Slot position, frame state and tap masks of the offered beat.
    always_comb begin
        if ({1'b0, r_col} >= w_eff) begin
            col_pre = '0;
            row_pre = r_row + 1'b1;
        end else begin
            col_pre = r_col;
            row_pre = r_row;
        end
        in_frame    = row_pre < h_eff;
        ignore_beat = s_axis_tuser && in_frame;
        cur         = in_frame ? t_pix'(s_axis_tdata) : '0;

        ctl.emit = (row_pre >= RowBits'(2)) || (row_pre == RowBits'(1) && col_pre != '0);
        ctl.last = {1'b0, row_pre} >= ({1'b0, h_eff} + 1'b1);

        // Output pixel lies one row up and one column back, or at the end of the row two rows up.
        if (col_pre != '0) begin
            orow = row_pre - 1'b1;
            ocol = col_pre - 1'b1;
        end else begin
            orow = row_pre - RowBits'(2);
            ocol = w_m1[ColBits-1:0];
        end
        ctl.row_top_ok   = orow != '0;
        ctl.row_bot_ok   = ({1'b0, orow} + 1'b1) < {1'b0, h_eff};
        ctl.col_left_ok  = ocol != '0;
        ctl.col_right_ok = ({1'b0, ocol} + 1'b1) < w_eff;

        col_inc = {1'b0, col_pre} + 1'b1;
        if (ctl.last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = row_pre + 1'b1;
        end else begin
            n_col = col_inc[ColBits-1:0];
            n_row = row_pre;
        end
    end

    // Handshake: the pipeline moves whenever the output register can move.
    assign adv           = !out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign s_fire        = s_axis_tvalid && adv;
    assign take          = s_fire && !ignore_beat;

    // Raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage B: waits for the line buffer read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_addr <= col_pre;
            r_b_cur  <= cur;
            r_b_ctl  <= ctl;
        end
    end

    rgbc_line_ram #(
        .Depth (MaxWidth),
        .Width ($bits(t_line_entry))
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_rd_addr (col_pre),
        .o_rd_data (ram_rd_data),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

    rgbc_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_rd_addr (col_pre),
        .i_b_valid (r_b_valid),
        .i_b_addr  (r_b_addr),
        .i_b_cur   (r_b_cur),
        .i_b_ctl   (r_b_ctl),
        .i_rd_data (t_line_entry'(ram_rd_data)),
        .o_we      (ram_we),
        .o_wr_addr (ram_wr_addr),
        .o_wr_data (ram_wr_data),
        .o_win     (win),
        .o_c_valid (c_valid),
        .o_c_ctl   (c_ctl)
    );

    rgbc_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (c_valid),
        .i_ctl      (c_ctl),
        .i_win      (win),
        .i_coef_top (r_coef_top),
        .i_coef_mid (r_coef_mid),
        .i_coef_bot (r_coef_bot),
        .o_valid    (out_valid),
        .o_pix      (out_pix),
        .o_last     (out_last)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = out_pix;
    assign m_axis_tlast  = out_last;

    // The final slot of a frame returns the counters to the origin.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && ctl.last) |=> (r_col == '0 && r_row == '0))
        else $error("counters not cleared after final slot");

    // An accepted slot lands in stage B with its column.
    a_stage_b_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_b_valid && r_b_addr == $past(col_pre)))
        else $error("stage B did not capture accepted slot");

    // An output stall freezes the counters and stage B.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_b_valid) && $stable(r_col) && $stable(r_row)))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

// ===== tb/rgb_convolution_3x3_core_tb.sv =====
// Self-checking testbench for the RGB 3x3 convolution core: a stream driver, a result monitor
// and a beat-level software predictor of the window arithmetic. Depends on rgbc_pkg and on
// rgb_convolution_3x3_core; needs no files or arguments.
`timescale 1ns / 1ps

module rgb_convolution_3x3_core_tb;
    import rgbc_pkg::*;

    localparam int CycleLimit   = 1000000;
    localparam int HoldCycles   = 400;
    localparam int DrainWait    = 12;
    localparam logic [CoefBits-1:0] CoefMin = {1'b1, {(CoefBits-1){1'b0}}};
    localparam logic [CoefBits-1:0] CoefMax = {1'b0, {(CoefBits-1){1'b1}}};

    typedef enum logic {OpPixel = 1'b0, OpDrain = 1'b1} t_op;

    // One entry of the feed: a beat to send, or a marker that waits for all results.
    typedef struct {
        t_op  op;
        t_pix px;
        bit   flush;
    } t_feed_item;

    typedef struct packed {
        t_pix px;
        logic is_last;
    } t_conv_result;

    // Clock, reset and DUT ports.
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [23:0]            s_axis_tdata = '0;   // in_red, in_green, in_blue
    logic                   s_axis_tuser = 1'b0; // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [23:0]            m_axis_tdata;        // out_red, out_green, out_blue
    logic                   m_axis_tlast;        // last_of_frame
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PaddrBits-1:0]   paddr = '0;
    logic [ApbDataBits-1:0] pwdata = '0;
    logic [ApbDataBits-1:0] prdata;
    logic                   pready;

    // Stimulus and checking bookkeeping.
    t_feed_item   pixel_feed_q[$];
    t_conv_result expected_pixels_q[$];
    t_feed_item   drive_beat;
    int           send_idle_pct = 31;
    int           recv_idle_pct = 57;
    int           hold_left = 0;
    int           cycle_count = 0;
    int           mismatches = 0;
    int           reg_errors = 0;
    int           beats_in = 0;
    int           results_seen = 0;
    int           frames_built = 0;
    int           reg_writes = 0;
    string        chan_names[3] = '{"out_red", "out_green", "out_blue"};

    // Predictor copy of the registers.
    logic [CoefRowBits-1:0]   kern[3] = '{'0, CoefRowBits'(256) << CoefBits, '0};
    logic [WidthRegBits-1:0]  width_reg = WidthRegBits'(2048);
    logic [HeightRegBits-1:0] height_reg = HeightRegBits'(1);

    // Predictor copy of the raster state.
    t_pix line_older[MaxWidth];
    t_pix line_newer[MaxWidth];
    t_pix win[3][3] = '{default: '0};
    int   in_col = 0;
    int   in_row = 0;

    rgb_convolution_3x3_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > MaxWidth) return MaxWidth;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        if (height_reg > MaxHeight) return MaxHeight;
        return int'(height_reg);
    endfunction

    // Advance the raster model by one accepted beat and queue the pixel it produces, if any.
    task automatic conv_predict(input t_op op, input t_pix px);
        int           w;
        int           h;
        int           col;
        int           idx;
        int           orow;
        int           ocol;
        bit           in_frame;
        bit           emit;
        bit           is_last;
        t_pix         cur;
        longint       acc;
        longint       val;
        logic signed [CoefBits-1:0] c;
        t_conv_result res;
        w = eff_width();
        h = eff_height();
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        col = in_col;
        in_frame = in_row < h;
        // A drain tick inside the frame is dropped without touching the state.
        if (op == OpDrain && in_frame) return;
        cur = in_frame ? px : '0;
        idx = (col < MaxWidth) ? col : 0;

        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = line_older[idx];
        win[1][2] = line_newer[idx];
        win[2][2] = cur;
        line_older[idx] = line_newer[idx];
        line_newer[idx] = cur;

        emit = in_row >= 2 || (in_row == 1 && col >= 1);
        is_last = in_row >= h + 1;

        if (emit) begin
            if (col >= 1) begin
                orow = in_row - 1;
                ocol = col - 1;
            end else begin
                orow = in_row - 2;
                ocol = w - 1;
            end
            for (int ch = 0; ch < 3; ch++) begin
                acc = 0;
                for (int r = 0; r < 3; r++) begin
                    // Rows and columns outside the image contribute nothing.
                    if (r == 0 && orow < 1) continue;
                    if (r == 2 && orow + 1 >= h) continue;
                    for (int k = 0; k < 3; k++) begin
                        if (k == 0 && ocol < 1) continue;
                        if (ocol + k - 1 >= w) continue;
                        c = kern[r][k*CoefBits +: CoefBits];
                        acc += longint'({1'b0, win[r][k][ch*8 +: 8]}) * longint'(c);
                    end
                end
                // Truncate once, then saturate to a byte.
                if (acc <= 0) begin
                    val = 0;
                end else begin
                    val = acc >>> CoefFracBits;
                    if (val > 255) val = 255;
                end
                res.px[ch*8 +: 8] = val[7:0];
            end
            res.is_last = is_last;
            expected_pixels_q.push_back(res);
        end

        if (is_last) begin
            in_col = 0;
            in_row = 0;
        end else begin
            in_col = col + 1;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
    endtask

    // Input driver: presents queued beats, idles at random, honors flush markers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                conv_predict(drive_beat.op, drive_beat.px);
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_feed_q.size() != 0 && pixel_feed_q[0].flush) begin
                    if (expected_pixels_q.size() == 0) void'(pixel_feed_q.pop_front());
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_feed_q.size() != 0 &&
                             $urandom_range(99) >= send_idle_pct) begin
                    drive_beat = pixel_feed_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= drive_beat.px;
                    s_axis_tuser  <= drive_beat.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each output beat and drives the receiver's back-pressure.
    always @(posedge i_clk) begin : result_monitor
        t_conv_result want;
        bit           start_hold;
        start_hold = 1'b0;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_pixels_q.size() == 0) begin
                $error("unexpected result beat: tdata %06h tlast %0b", m_axis_tdata,
                       m_axis_tlast);
                mismatches++;
            end else begin
                want = expected_pixels_q.pop_front();
                for (int ch = 0; ch < 3; ch++) begin
                    if (m_axis_tdata[ch*8 +: 8] !== want.px[ch*8 +: 8]) begin
                        $error("%s: expected %0d, actual %0d", chan_names[ch],
                               want.px[ch*8 +: 8], m_axis_tdata[ch*8 +: 8]);
                        mismatches++;
                    end
                end
                if (m_axis_tlast !== want.is_last) begin
                    $error("last_of_frame: expected %0b, actual %0b", want.is_last,
                           m_axis_tlast);
                    mismatches++;
                end
            end
            // Every so often the receiver stops for a long stretch to fill the pipeline.
            start_hold = (results_seen % 1500 == 600);
        end
        if (start_hold) begin
            hold_left <= HoldCycles;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_pix rand_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return 24'($urandom);
        endcase
    endfunction

    // A kernel row with extreme, zero, moderate or arbitrary coefficients and junk above it.
    function automatic logic [63:0] rand_coef_row();
        logic [63:0]         v;
        logic [CoefBits-1:0] c;
        v = {$urandom, $urandom};
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(5))
                0: c = CoefMin;
                1: c = CoefMax;
                2: c = '0;
                3: c = CoefBits'($urandom_range(1024) - 512);
                default: c = CoefBits'($urandom);
            endcase
            v[k*CoefBits +: CoefBits] = c;
        end
        return v;
    endfunction

    function automatic logic [63:0] reg_model(input t_reg_idx idx);
        case (idx)
            RegCoefTop:     return 64'(kern[0]);
            RegCoefMiddle:  return 64'(kern[1]);
            RegCoefBottom:  return 64'(kern[2]);
            RegImageWidth:  return 64'(width_reg);
            RegImageHeight: return 64'(height_reg);
            default:        return '0;
        endcase
    endfunction

    task automatic push_beat(input t_op op, input t_pix px);
        pixel_feed_q.push_back('{op, px, 1'b0});
    endtask

    // One register transfer: setup phase, then access phase.
    task automatic apb_xfer(input bit wr, input t_reg_idx idx, input logic [63:0] wdata,
                            output logic [63:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_check(input t_reg_idx idx);
        logic [63:0] got;
        apb_xfer(1'b0, idx, '0, got);
        if (got !== reg_model(idx)) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, reg_model(idx), got);
            reg_errors++;
        end
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [63:0] val);
        logic [63:0] unused;
        apb_xfer(1'b1, idx, val, unused);
        case (idx)
            RegCoefTop:     kern[0] = val[CoefRowBits-1:0];
            RegCoefMiddle:  kern[1] = val[CoefRowBits-1:0];
            RegCoefBottom:  kern[2] = val[CoefRowBits-1:0];
            RegImageWidth:  width_reg = val[WidthRegBits-1:0];
            RegImageHeight: height_reg = val[HeightRegBits-1:0];
            default: ;
        endcase
        reg_writes++;
        reg_check(idx);
    endtask

    // Wait until every queued beat is sent and every predicted pixel has come out.
    task automatic wait_idle();
        while (pixel_feed_q.size() != 0 || s_axis_tvalid || expected_pixels_q.size() != 0)
            @(negedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    // Queue one complete frame at the current size; noisy frames add ignored drain ticks,
    // pixels that stand in for drain ticks, and pauses that wait for all results.
    task automatic build_frame(input bit noisy, output int n_items);
        int w;
        int h;
        w = eff_width();
        h = eff_height();
        for (int p = 0; p < w * h; p++) begin
            if (noisy && $urandom_range(15) == 0) push_beat(OpDrain, rand_pixel());
            if (noisy && $urandom_range(79) == 0) pixel_feed_q.push_back('{OpPixel, '0, 1'b1});
            push_beat(OpPixel, rand_pixel());
        end
        for (int d = 0; d <= w; d++) begin
            if (noisy && $urandom_range(3) == 0) push_beat(OpPixel, rand_pixel());
            else push_beat(OpDrain, rand_pixel());
        end
        if (noisy && $urandom_range(3) == 0) push_beat(OpDrain, rand_pixel());
        n_items = w * h + w + 1;
        frames_built++;
    endtask

    initial begin : stimulus
        int          n;
        int          rand_items;
        logic [63:0] v;
        rand_items = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of every register.
        for (int i = 0; i < 5; i++) reg_check(t_reg_idx'(i));

        // Reset kernel is the identity; run it over a small frame.
        cfg_write(RegImageWidth, 64'd4);
        cfg_write(RegImageHeight, 64'd3);
        build_frame(1'b0, n);
        wait_idle();

        // Largest coefficients saturate high; a drain tick ahead of the frame is ignored,
        // and a pixel after the last one acts as a drain tick.
        for (int i = 0; i < 3; i++) cfg_write(t_reg_idx'(i), {28'h0, {3{CoefMax}}});
        cfg_write(RegImageWidth, 64'd3);
        cfg_write(RegImageHeight, 64'd3);
        push_beat(OpDrain, '1);
        for (int p = 0; p < 9; p++) push_beat(OpPixel, (p % 2) ? t_pix'('1) : t_pix'('0));
        for (int d = 0; d < 3; d++) push_beat(OpDrain, '0);
        push_beat(OpPixel, 24'h5A_A5_3C);
        frames_built++;
        wait_idle();

        // Most negative coefficients clamp to zero.
        for (int i = 0; i < 3; i++) cfg_write(t_reg_idx'(i), {28'hFFFFFFF, {3{CoefMin}}});
        cfg_write(RegImageWidth, 64'd2);
        cfg_write(RegImageHeight, 64'd2);
        for (int p = 0; p < 4; p++) push_beat(OpPixel, '1);
        for (int d = 0; d < 3; d++) push_beat(OpDrain, '0);
        frames_built++;
        wait_idle();

        // Zero width and height act as a single pixel; the first drain tick gives nothing.
        cfg_write(RegCoefMiddle, rand_coef_row());
        cfg_write(RegImageWidth, 64'd0);
        cfg_write(RegImageHeight, 64'd0);
        push_beat(OpPixel, 24'h80_7F_01);
        push_beat(OpDrain, '1);
        push_beat(OpDrain, '0);
        frames_built++;
        wait_idle();

        // Random kernels and small frame sizes, with noise.
        while (rand_items < 1500) begin
            if (rand_items >= 1000) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (rand_items >= 500) begin
                send_idle_pct = 57;
                recv_idle_pct = 31;
            end
            wait_idle();
            for (int i = 0; i < 3; i++)
                if ($urandom_range(2) != 0) cfg_write(t_reg_idx'(i), rand_coef_row());
            if ($urandom_range(2) != 0) begin
                v = {$urandom, $urandom};
                case ($urandom_range(9))
                    0: v[WidthRegBits-1:0] = '0;
                    1: v[WidthRegBits-1:0] = WidthRegBits'(1);
                    2: v[WidthRegBits-1:0] = WidthRegBits'($urandom_range(64, 20));
                    default: v[WidthRegBits-1:0] = WidthRegBits'($urandom_range(10, 2));
                endcase
                cfg_write(RegImageWidth, v);
            end
            if ($urandom_range(2) != 0) begin
                v = {$urandom, $urandom};
                case ($urandom_range(7))
                    0: v[HeightRegBits-1:0] = '0;
                    1: v[HeightRegBits-1:0] = HeightRegBits'(1);
                    default: v[HeightRegBits-1:0] = HeightRegBits'($urandom_range(8, 2));
                endcase
                cfg_write(RegImageHeight, v);
            end
            repeat ($urandom_range(3, 1)) begin
                build_frame(1'b1, n);
                rand_items += n;
            end
        end
        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Run covered %0d input beats in %0d frames with %0d register writes;",
                 beats_in, frames_built, reg_writes);
        $display("%0d result beats were compared against the predictor.", results_seen);
        if (mismatches + reg_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
